// ----- rtl/bba_pkg.sv -----
// ============================================================================
// Buddy allocator package
// Shared types, constants and codes for the buddy block allocator.
// ============================================================================
package bba_pkg;

    localparam int MAX_ORDER_DEF    = 10;
    localparam int POOL_RECORDS_DEF = 1024;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ORDER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ORDER = 1'd1;

    // Command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NO_BLOCK  = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  owner_id;
        logic [15:0] request_size;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  block_addr;
        logic [3:0]  block_order;
    } t_rsp;

endpackage

// ----- rtl/buddy_block_allocator.sv -----
// ============================================================================
// Buddy block allocator
// Binary buddy allocator with per-order free lists and an owner list, all
// records held in one single-port synchronous memory.
// ============================================================================
// Operation: a request is accepted, then list records are visited, orders
//   are scanned, blocks are split or merged, and the result is finished.
// Throughput: one request at a time; a walk may visit up to POOL_RECORDS
//   owner or free records.
// Reset: lists are emptied and the record pool is rebuilt by a pass over
//   every record, also after every configuration write.
module buddy_block_allocator #(
    parameter int MAX_ORDER    = bba_pkg::MAX_ORDER_DEF,
    parameter int POOL_RECORDS = bba_pkg::POOL_RECORDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bba_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_req_valid,
    output logic                           o_req_ready,
    input  bba_pkg::t_req                  i_req,
    output logic                           o_rsp_valid,
    input  logic                           i_rsp_ready,
    output bba_pkg::t_rsp                  o_rsp
);
    import bba_pkg::*;

    localparam int PW = $clog2(POOL_RECORDS + 1);   // pointer incl. nil
    localparam int IW = $clog2(POOL_RECORDS);       // memory index
    localparam int AW = MAX_ORDER + 1;              // address, room for sums
    localparam int OW = $clog2(MAX_ORDER + 2);      // order
    localparam logic [PW-1:0] NIL = PW'(POOL_RECORDS);
    localparam logic [PW-1:0] LAST = PW'(POOL_RECORDS - 1);

    typedef struct packed {
        logic [AW-1:0] addr;
        logic [OW-1:0] order;
        logic [7:0]    id;
        logic [PW-1:0] next;
    } t_rec;

    typedef enum logic [4:0] {
        S_INIT, S_INIT_HEAD, S_IDLE, S_A_SCAN, S_A_RD_TOP, S_A_SPL_RD,
        S_A_SPL_W1, S_A_SPL_W2, S_A_TAKE_RD, S_A_TAKE_WR, S_F_RD, S_F_WAIT,
        S_F_UNLINK_RD, S_F_UNLINK_WR, S_F_BUD, S_F_BRD, S_F_BWAIT,
        S_F_BUNLINK, S_F_BUNLINK_RD, S_F_PUSH, S_RSP
    } t_state;

    // Record memory: one port, registered read data.
    t_rec          mem [POOL_RECORDS];
    logic          mem_we;
    logic [IW-1:0] mem_addr;
    t_rec          mem_wd;
    t_rec          mem_rd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wd;
        end
        mem_rd <= mem[mem_addr];
    end

    t_state          r_state;
    logic [3:0]      r_min, r_max;
    logic [PW-1:0]   r_heads [MAX_ORDER+1];
    logic [PW-1:0]   r_owned, r_spare;
    logic [PW:0]     r_spare_cnt;
    logic [PW-1:0]   r_cnt;
    t_req            r_req;
    t_rsp            r_rsp;
    logic [OW-1:0]   r_k, r_i;
    logic [PW-1:0]   r_n, r_prev, r_top, r_p, r_t, r_tp;
    t_rec            r_rec, r_top_rec;
    logic [AW-1:0]   r_bud;

    // Effective top order and requested order; the request order may reach
    // 16, so the too-large check is made at full width.
    logic [OW-1:0] top_o;
    logic [4:0]    size_o;
    logic [4:0]    want_w;
    logic          want_big;
    logic [OW-1:0] want_o;
    always_comb begin
        top_o = (32'(r_max) > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(r_max);
        size_o = 5'd16;
        for (int b = 16; b >= 0; b--) begin
            if (17'(i_req.request_size) <= (17'd1 << b)) begin
                size_o = 5'(b);
            end
        end
        want_w   = (size_o < 5'(r_min)) ? 5'(r_min) : size_o;
        want_big = (want_w > 5'(top_o));
        want_o   = OW'(want_w);
    end

    // Memory port selection.
    always_comb begin
        mem_we   = 1'b0;
        mem_addr = IW'(r_cnt);
        mem_wd   = '0;
        unique case (r_state)
            S_INIT: begin
                mem_we   = 1'b1;
                mem_wd.next = (r_cnt == LAST) ? NIL : r_cnt + 1'b1;
            end
            S_INIT_HEAD: begin
                mem_we = 1'b1;
                mem_addr = '0;
                mem_wd.order = top_o;
                mem_wd.next = NIL;
            end
            S_A_RD_TOP:    mem_addr = IW'(r_top);
            S_A_SPL_RD:    mem_addr = IW'(r_spare);
            S_A_SPL_W1: begin
                mem_we = 1'b1;
                mem_addr = IW'(r_p);
                mem_wd.addr = r_top_rec.addr + (AW'(1) << (r_i - 1'b1));
                mem_wd.order = r_i - 1'b1;
                mem_wd.next = r_heads[r_i - 1'b1];
            end
            S_A_SPL_W2: begin
                mem_we = 1'b1;
                mem_addr = IW'(r_top);
                mem_wd = r_top_rec;
                mem_wd.order = r_i;
                mem_wd.next = r_p;
            end
            S_A_TAKE_RD:   mem_addr = IW'(r_heads[r_k]);
            S_A_TAKE_WR: begin
                mem_we = 1'b1;
                mem_addr = IW'(r_t);
                mem_wd = mem_rd;
                mem_wd.id = r_req.owner_id;
                mem_wd.next = r_owned;
            end
            S_F_RD:        mem_addr = IW'(r_n);
            S_F_UNLINK_RD: mem_addr = IW'(r_prev);
            S_F_UNLINK_WR: begin
                mem_we = 1'b1;
                mem_addr = IW'(r_prev);
                mem_wd = mem_rd;
                mem_wd.next = r_rec.next;
            end
            S_F_BRD:       mem_addr = IW'(r_t);
            S_F_BUNLINK_RD: mem_addr = IW'(r_tp);
            S_F_BUNLINK: begin
                mem_we = 1'b1;
                mem_addr = IW'(r_tp);
                mem_wd = mem_rd;
                mem_wd.next = r_top_rec.next;
            end
            S_F_PUSH: begin
                mem_we = 1'b1;
                mem_addr = IW'(r_n);
                mem_wd = r_rec;
                mem_wd.next = r_heads[r_i];
            end
            default: begin
                if (r_state == S_F_BUD && r_t != NIL) begin
                    mem_we = 1'b1;       // spare record gets linked to spare list
                    mem_addr = IW'(r_t);
                    mem_wd = r_top_rec;
                    mem_wd.next = r_spare;
                end
            end
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_RSP);
    assign o_rsp       = r_rsp;

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_min <= '0;
            r_max <= 4'd10;
            r_cnt <= '0;
            r_owned <= NIL;
            r_spare <= '0;
            r_spare_cnt <= (PW+1)'(POOL_RECORDS);
            for (int j = 0; j <= MAX_ORDER; j++) r_heads[j] <= NIL;
        end else if (i_cfg_we && (i_cfg_idx == REG_MIN_ORDER ||
                                  i_cfg_idx == REG_MAX_ORDER)) begin
            if (i_cfg_idx == REG_MIN_ORDER) r_min <= i_cfg_data;
            else                            r_max <= i_cfg_data;
            r_state <= S_INIT;
            r_cnt <= '0;
            r_owned <= NIL;
            r_spare <= '0;
            r_spare_cnt <= (PW+1)'(POOL_RECORDS);
            for (int j = 0; j <= MAX_ORDER; j++) r_heads[j] <= NIL;
        end else begin
            unique case (r_state)
                S_INIT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST) r_state <= S_INIT_HEAD;
                end
                S_INIT_HEAD: begin
                    r_spare <= (POOL_RECORDS > 1) ? PW'(1) : NIL;
                    r_spare_cnt <= (PW+1)'(POOL_RECORDS - 1);
                    r_heads[top_o] <= '0;
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req <= i_req;
                        r_k <= want_o;
                        r_i <= want_o;
                        r_n <= r_owned;
                        r_prev <= NIL;
                        if (i_req.cmd == CMD_ALLOC) begin
                            if (want_big) begin
                                r_rsp <= '{status: ST_NO_BLOCK, block_addr: '0,
                                           block_order: '0};
                                r_state <= S_RSP;
                            end else begin
                                r_rsp <= '0;
                                r_state <= S_A_SCAN;
                            end
                        end else if (r_owned == NIL) begin
                            r_rsp <= '{status: ST_NOT_FOUND, block_addr: '0,
                                       block_order: '0};
                            r_state <= S_RSP;
                        end else begin
                            r_rsp <= '0;
                            r_state <= S_F_RD;
                        end
                    end
                end
                // Search upward for a non-empty list.
                S_A_SCAN: begin
                    if (r_i > top_o) begin
                        r_rsp.status <= ST_NO_BLOCK;
                        r_state <= S_RSP;
                    end else if (r_heads[r_i] != NIL) begin
                        if (r_spare_cnt < (PW+1)'(r_i - r_k)) begin
                            r_rsp.status <= ST_NO_BLOCK;
                            r_state <= S_RSP;
                        end else if (r_i == r_k) begin
                            r_state <= S_A_TAKE_RD;
                        end else begin
                            r_top <= r_heads[r_i];
                            r_state <= S_A_RD_TOP;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_A_RD_TOP: r_state <= S_A_SPL_RD;
                S_A_SPL_RD: begin
                    // Top record arrives; pop it and take a spare.
                    r_top_rec <= mem_rd;
                    r_heads[r_i] <= mem_rd.next;
                    r_p <= r_spare;
                    r_state <= S_A_SPL_W1;
                end
                S_A_SPL_W1: begin
                    r_spare <= mem_rd.next;
                    r_spare_cnt <= r_spare_cnt - 1'b1;
                    r_i <= r_i - 1'b1;
                    r_state <= S_A_SPL_W2;
                end
                S_A_SPL_W2: begin
                    r_heads[r_i] <= r_top;
                    if (r_i == r_k) begin
                        r_state <= S_A_TAKE_RD;
                    end else begin
                        r_state <= S_A_RD_TOP;
                        r_top <= r_top;
                        r_i <= r_i;
                    end
                end
                S_A_TAKE_RD: begin
                    r_t <= r_heads[r_k];
                    r_state <= S_A_TAKE_WR;
                end
                S_A_TAKE_WR: begin
                    r_heads[r_k] <= mem_rd.next;
                    r_owned <= r_t;
                    r_rsp.block_addr <= 10'(mem_rd.addr);
                    r_rsp.block_order <= 4'(r_k);
                    r_state <= S_RSP;
                end
                // Walk the owner list.
                S_F_RD: r_state <= S_F_WAIT;
                S_F_WAIT: begin
                    if (mem_rd.id == r_req.owner_id) begin
                        r_rec <= mem_rd;
                        r_i <= mem_rd.order;
                        if (r_prev == NIL) begin
                            r_owned <= mem_rd.next;
                            r_state <= S_F_BUD;
                            r_t <= NIL;
                        end else begin
                            r_state <= S_F_UNLINK_RD;
                        end
                    end else if (mem_rd.next == NIL) begin
                        r_rsp.status <= ST_NOT_FOUND;
                        r_state <= S_RSP;
                    end else begin
                        r_prev <= r_n;
                        r_n <= mem_rd.next;
                        r_state <= S_F_RD;
                    end
                end
                S_F_UNLINK_RD: r_state <= S_F_UNLINK_WR;
                S_F_UNLINK_WR: begin
                    r_t <= NIL;
                    r_state <= S_F_BUD;
                end
                // Start a buddy search at the current order.
                S_F_BUD: begin
                    if (r_t != NIL) begin
                        r_spare <= r_t;
                        r_spare_cnt <= r_spare_cnt + 1'b1;
                        r_t <= NIL;
                    end else if (r_i >= top_o) begin
                        r_state <= S_F_PUSH;
                    end else begin
                        r_bud <= r_rec.addr[r_i] ? r_rec.addr - (AW'(1) << r_i)
                                                 : r_rec.addr + (AW'(1) << r_i);
                        r_t <= r_heads[r_i];
                        r_tp <= NIL;
                        if (r_heads[r_i] == NIL) r_state <= S_F_PUSH;
                        else                      r_state <= S_F_BRD;
                    end
                end
                S_F_BRD: r_state <= S_F_BWAIT;
                S_F_BWAIT: begin
                    if (mem_rd.addr == r_bud) begin
                        r_top_rec <= mem_rd;
                        if (r_tp == NIL) begin
                            r_heads[r_i] <= mem_rd.next;
                            r_i <= r_i + 1'b1;
                            r_rec.addr <= (r_rec.addr < r_bud) ? r_rec.addr : r_bud;
                            r_rec.order <= r_i + 1'b1;
                            r_state <= S_F_BUD;
                        end else begin
                            r_state <= S_F_BUNLINK_RD;
                        end
                    end else if (mem_rd.next == NIL) begin
                        r_t <= NIL;
                        r_state <= S_F_PUSH;
                    end else begin
                        r_tp <= r_t;
                        r_t <= mem_rd.next;
                        r_state <= S_F_BRD;
                    end
                end
                S_F_BUNLINK_RD: r_state <= S_F_BUNLINK;
                S_F_BUNLINK: begin
                    r_i <= r_i + 1'b1;
                    r_rec.addr <= (r_rec.addr < r_bud) ? r_rec.addr : r_bud;
                    r_rec.order <= r_i + 1'b1;
                    r_state <= S_F_BUD;
                end
                S_F_PUSH: begin
                    r_heads[r_i] <= r_n;
                    r_rsp.block_addr <= 10'(r_rec.addr);
                    r_rsp.block_order <= 4'(r_i);
                    r_state <= S_RSP;
                end
                S_RSP: begin
                    if (i_rsp_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_INIT;
            endcase
        end
    end

    // Checks.
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_req_ready && o_rsp_valid)) else $error("ready while result pending");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != ST_DONE |-> o_rsp.block_addr == '0
        && o_rsp.block_order == '0) else $error("failed result carries data");
    a_spare_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spare_cnt <= (PW+1)'(POOL_RECORDS)) else $error("spare count overflow");

endmodule
